### sv/fvn_pkg.sv
`timescale 1ns / 1ps
package fvn_pkg;

  localparam int LANE_W = 25;
  localparam int POW_W  = 33;
  localparam int AMP_W  = 36;

  localparam logic [POW_W-1:0] POW_INIT = 33'd256;
  localparam logic [POW_W-1:0] POW_CAP  = 33'h1_0000_0000;
  localparam logic [AMP_W-1:0] AMP_INIT = 36'd16384;
  localparam logic [AMP_W-1:0] AMP_CAP  = 36'h8_0000_0000;
  localparam logic [11:0]      LAC_MIN  = 12'd256;
  localparam logic [15:0]      PERS_MIN = 16'd164;

  localparam logic [2:0] CFG_OCT = 3'd0;
  localparam logic [2:0] CFG_LAC = 3'd1;
  localparam logic [2:0] CFG_PER = 3'd2;
  localparam logic [2:0] CFG_GW  = 3'd3;
  localparam logic [2:0] CFG_GH  = 3'd4;

  localparam logic [3:0]  RST_OCT = 4'd4;
  localparam logic [11:0] RST_LAC = 12'd512;
  localparam logic [15:0] RST_PER = 16'd8192;
  localparam logic [8:0]  RST_GW  = 9'd256;
  localparam logic [8:0]  RST_GH  = 9'd256;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [1:0] DOP_BLEND = 2'd0;
  localparam logic [1:0] DOP_WMOD  = 2'd1;
  localparam logic [1:0] DOP_PMOD  = 2'd2;

  localparam logic [1:0] CRN_AA = 2'd0;
  localparam logic [1:0] CRN_BA = 2'd1;
  localparam logic [1:0] CRN_AB = 2'd2;
  localparam logic [1:0] CRN_BB = 2'd3;

  localparam logic [1:0] BL_BOT = 2'd0;
  localparam logic [1:0] BL_TOP = 2'd1;
  localparam logic [1:0] BL_MID = 2'd2;

  typedef struct packed {
    logic       mem_we;
    logic       q_init;
    logic       pow_step;
    logic       amp_step;
    logic       div_start;
    logic [1:0] div_op;
    logic       div_cap;
    logic       crn;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       cap_en;
    logic [1:0] cap_sel;
    logic       bl_en;
    logic [1:0] bl_sel;
    logic       mul;
    logic       acc;
    logic       fd_start;
    logic       fd_cap;
    logic       out_fire;
  } ctl_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic pow_done;
    logic oct_last;
    logic div_done;
    logic fd_done;
  } ctl_sts_t;

endpackage

### sv/fvn_div.sv
`timescale 1ns / 1ps
module fvn_div #(
  parameter int W = 25
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);
  localparam int CNW = $clog2(W + 1);

  logic [CNW-1:0] cnt_r;
  logic           run_r;
  logic           done_r;
  logic [W-1:0]   quot_r;
  logic [W-1:0]   rem_r;
  logic [W-1:0]   dvs_r;
  logic [W:0]     t;
  logic [W:0]     diff;
  logic           ge;

  always_comb begin
    t    = {rem_r, quot_r[W-1]};
    ge   = t >= {1'b0, dvs_r};
    diff = t - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNW'(W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
    end else if (run_r) begin
      quot_r <= {quot_r[W-2:0], ge};
      rem_r  <= ge ? diff[W-1:0] : t[W-1:0];
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;
endmodule

### sv/fvn_ctrl.sv
`timescale 1ns / 1ps
module fvn_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_action,
  input  fvn_pkg::ctl_sts_t sts,
  output fvn_pkg::ctl_cmd_t cmd,
  output logic              busy
);
  import fvn_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_POW  = 5'd1;
  localparam logic [4:0] S_AMP  = 5'd2;
  localparam logic [4:0] S_D0   = 5'd3;
  localparam logic [4:0] S_D0W  = 5'd4;
  localparam logic [4:0] S_D1   = 5'd5;
  localparam logic [4:0] S_D1W  = 5'd6;
  localparam logic [4:0] S_D2   = 5'd7;
  localparam logic [4:0] S_D2W  = 5'd8;
  localparam logic [4:0] S_CRN  = 5'd9;
  localparam logic [4:0] S_RD0  = 5'd10;
  localparam logic [4:0] S_RD1  = 5'd11;
  localparam logic [4:0] S_RD2  = 5'd12;
  localparam logic [4:0] S_RD3  = 5'd13;
  localparam logic [4:0] S_RD4  = 5'd14;
  localparam logic [4:0] S_BL0  = 5'd15;
  localparam logic [4:0] S_BL1  = 5'd16;
  localparam logic [4:0] S_BL2  = 5'd17;
  localparam logic [4:0] S_MUL  = 5'd18;
  localparam logic [4:0] S_ACC  = 5'd19;
  localparam logic [4:0] S_FD   = 5'd20;
  localparam logic [4:0] S_FDW  = 5'd21;
  localparam logic [4:0] S_OUT  = 5'd22;

  logic [4:0] state_r;
  logic [4:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_action == ACT_LOAD) begin
            cmd.mem_we = 1'b1;
          end else begin
            cmd.q_init = 1'b1;
            state_nxt  = sts.n_zero ? S_OUT : S_POW;
          end
        end
      end
      S_POW: begin
        if (sts.pow_done) state_nxt = S_AMP;
        else cmd.pow_step = 1'b1;
      end
      S_AMP: begin
        cmd.amp_step = 1'b1;
        state_nxt    = S_D0;
      end
      S_D0: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DOP_BLEND;
        state_nxt     = S_D0W;
      end
      S_D0W: begin
        cmd.div_op = DOP_BLEND;
        if (sts.div_done) begin
          cmd.div_cap = 1'b1;
          state_nxt   = S_D1;
        end
      end
      S_D1: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DOP_WMOD;
        state_nxt     = S_D1W;
      end
      S_D1W: begin
        cmd.div_op = DOP_WMOD;
        if (sts.div_done) begin
          cmd.div_cap = 1'b1;
          state_nxt   = S_D2;
        end
      end
      S_D2: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DOP_PMOD;
        state_nxt     = S_D2W;
      end
      S_D2W: begin
        cmd.div_op = DOP_PMOD;
        if (sts.div_done) begin
          cmd.div_cap = 1'b1;
          state_nxt   = S_CRN;
        end
      end
      S_CRN: begin
        cmd.crn   = 1'b1;
        state_nxt = S_RD0;
      end
      S_RD0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = CRN_AA;
        state_nxt  = S_RD1;
      end
      S_RD1: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = CRN_BA;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = CRN_AA;
        state_nxt   = S_RD2;
      end
      S_RD2: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = CRN_AB;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = CRN_BA;
        state_nxt   = S_RD3;
      end
      S_RD3: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = CRN_BB;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = CRN_AB;
        state_nxt   = S_RD4;
      end
      S_RD4: begin
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = CRN_BB;
        state_nxt   = S_BL0;
      end
      S_BL0: begin
        cmd.bl_en  = 1'b1;
        cmd.bl_sel = BL_BOT;
        state_nxt  = S_BL1;
      end
      S_BL1: begin
        cmd.bl_en  = 1'b1;
        cmd.bl_sel = BL_TOP;
        state_nxt  = S_BL2;
      end
      S_BL2: begin
        cmd.bl_en  = 1'b1;
        cmd.bl_sel = BL_MID;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.oct_last ? S_FD : S_POW;
      end
      S_FD: begin
        cmd.fd_start = 1'b1;
        state_nxt    = S_FDW;
      end
      S_FDW: begin
        if (sts.fd_done) begin
          cmd.fd_cap = 1'b1;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        cmd.out_fire = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign busy = state_r != S_IDLE;
endmodule

### sv/fvn_dpath.sv
`timescale 1ns / 1ps
module fvn_dpath #(
  parameter int GRID_SIDE   = 256,
  parameter int MAX_OCTAVES = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic [7:0]        in_pos_x,
  input  logic [7:0]        in_pos_y,
  input  logic [15:0]       in_sample,
  input  fvn_pkg::ctl_cmd_t cmd,
  output fvn_pkg::ctl_sts_t sts,
  output logic              out_valid,
  output logic [7:0]        out_x,
  output logic [7:0]        out_y,
  output logic [15:0]       out_noise_value
);
  import fvn_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int GWW = $clog2(GRID_SIDE + 1);
  localparam int AW  = $clog2(GRID_SIDE * GRID_SIDE);
  localparam int OW  = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
  localparam int TW  = AMP_W + $clog2(MAX_OCTAVES + 1);
  localparam int SW  = SB + AMP_W + $clog2(MAX_OCTAVES + 1);
  localparam int PW  = SB + AMP_W;

  function automatic logic [GWW-1:0] clamp_dim(input logic [8:0] v);
    int unsigned vi;
    vi = 32'(v);
    if (vi < 1) vi = 1;
    else if (vi > GRID_SIDE) vi = GRID_SIDE;
    return GWW'(vi);
  endfunction

  function automatic logic [7:0] mod_side(input logic [7:0] v);
    logic [8:0] r;
    r = '0;
    for (int k = 7; k >= 0; k--) begin
      r = {r[7:0], v[k]};
      if (32'(r) >= GRID_SIDE) r = r - 9'(GRID_SIDE);
    end
    return r[7:0];
  endfunction

  function automatic logic [GWW-1:0] wrap_add(input logic [GWW-1:0] a, b, m);
    logic [GWW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[GWW-1:0];
  endfunction

  function automatic logic [SB-1:0] lerp(input logic [SB-1:0] v0, v1,
                                         input logic [14:0] a);
    logic signed [SB:0]    d;
    logic signed [SB+16:0] m;
    logic signed [SB+1:0]  s;
    d = $signed({1'b0, v1}) - $signed({1'b0, v0});
    m = d * $signed({1'b0, a});
    s = $signed({2'b0, v0}) + $signed(m[SB+16:15]);
    return s[SB-1:0];
  endfunction

  logic [3:0]  oct_r;
  logic [11:0] lac_r;
  logic [15:0] per_r;
  logic [8:0]  gw_r;
  logic [8:0]  gh_r;

  logic [11:0]    lac_c;
  logic [15:0]    per_c;
  logic [GWW-1:0] gw_c;
  logic [GWW-1:0] gh_c;
  logic [OW-1:0]  o_init;

  logic [7:0]       px_r, py_r;
  logic [OW-1:0]    o_r, i_r;
  logic [POW_W-1:0] p_r;
  logic [AMP_W-1:0] amp_r;
  logic [TW-1:0]    tot_r;
  logic [SW-1:0]    sum_r;
  logic [14:0]      ax_r, ay_r;
  logic [7:0]       x0_r, y0_r;
  logic [GWW-1:0]   rwx_r, rwy_r, rmx_r, rmy_r;
  logic [GWW-1:0]   xa_r, xb_r, ya_r, yb_r;
  logic [SB-1:0]    v_r [4];
  logic [SB-1:0]    bot_r, top_r, ov_r;
  logic [PW-1:0]    prod_r;
  logic [15:0]      res_r;
  logic             out_valid_r;
  logic [7:0]       out_x_r, out_y_r;
  logic [15:0]      out_n_r;

  logic [POW_W+11:0] pprod;
  logic [POW_W-1:0]  p_n;
  logic [AMP_W+15:0] aprod;
  logic [AMP_W-1:0]  amp_n;
  logic [LANE_W-1:0] w;
  logic [LANE_W-1:0] dx_a, dx_b, dy_a, dy_b;
  logic [LANE_W-1:0] qx, rx, qy, ry;
  logic              dx_done, dy_done;
  logic [15:0]       x0m, y0m;
  logic [SW-1:0]     fq, fr;
  logic              fd_done;

  logic [SB-1:0]    grid_mem [GRID_SIDE*GRID_SIDE];
  logic [SB-1:0]    rdata_r;
  logic [AW-1:0]    raddr, waddr;
  logic [SB+15:0]   sx;
  logic [SB-1:0]    wdata;
  logic [GWW-1:0]   rx_c, ry_c;

  always_comb begin
    lac_c  = (lac_r < LAC_MIN) ? LAC_MIN : lac_r;
    per_c  = (per_r < PERS_MIN) ? PERS_MIN : per_r;
    gw_c   = clamp_dim(gw_r);
    gh_c   = clamp_dim(gh_r);
    if (32'(oct_r) >= MAX_OCTAVES) o_init = OW'(MAX_OCTAVES - 1);
    else o_init = OW'(oct_r - 4'd1);

    pprod = {12'b0, p_r} * {{POW_W{1'b0}}, lac_c};
    p_n   = (pprod[POW_W+11:8] > {4'b0, POW_CAP}) ? POW_CAP : pprod[POW_W-1+8:8];
    aprod = {16'b0, amp_r} * {{AMP_W{1'b0}}, per_c};
    amp_n = (aprod[AMP_W+15:14] > {2'b0, AMP_CAP}) ? AMP_CAP : aprod[AMP_W-1+14:14];
    w     = p_r[POW_W-1:8];

    case (cmd.div_op)
      DOP_WMOD: begin
        dx_a = w;
        dx_b = LANE_W'(gw_c);
        dy_a = w;
        dy_b = LANE_W'(gh_c);
      end
      DOP_PMOD: begin
        dx_a = LANE_W'(x0_r);
        dx_b = LANE_W'(gw_c);
        dy_a = LANE_W'(y0_r);
        dy_b = LANE_W'(gh_c);
      end
      default: begin
        dx_a = LANE_W'({px_r, 15'b0});
        dx_b = w;
        dy_a = LANE_W'({py_r, 15'b0});
        dy_b = w;
      end
    endcase

    x0m = qx[22:15] * w[7:0];
    y0m = qy[22:15] * w[7:0];

    case (cmd.rd_sel)
      CRN_BA:  {rx_c, ry_c} = {xb_r, ya_r};
      CRN_AB:  {rx_c, ry_c} = {xa_r, yb_r};
      CRN_BB:  {rx_c, ry_c} = {xb_r, yb_r};
      default: {rx_c, ry_c} = {xa_r, ya_r};
    endcase
    raddr = AW'(32'(ry_c) * GRID_SIDE + 32'(rx_c));
    waddr = AW'(32'(mod_side(in_pos_y)) * GRID_SIDE + 32'(mod_side(in_pos_x)));
    sx    = {{SB{1'b0}}, in_sample};
    wdata = sx[SB-1:0];

    sts.n_zero   = oct_r == 4'd0;
    sts.pow_done = i_r == o_r;
    sts.oct_last = o_r == '0;
    sts.div_done = dx_done & dy_done;
    sts.fd_done  = fd_done;
  end

  fvn_div #(.W(LANE_W)) u_div_x (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(dx_a), .divisor(dx_b),
    .done(dx_done), .quot(qx), .rem(rx)
  );

  fvn_div #(.W(LANE_W)) u_div_y (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(dy_a), .divisor(dy_b),
    .done(dy_done), .quot(qy), .rem(ry)
  );

  fvn_div #(.W(SW)) u_div_f (
    .clk(clk), .rst_n(rst_n), .start(cmd.fd_start), .dividend(sum_r),
    .divisor(SW'(tot_r)), .done(fd_done), .quot(fq), .rem(fr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oct_r <= RST_OCT;
      lac_r <= RST_LAC;
      per_r <= RST_PER;
      gw_r  <= RST_GW;
      gh_r  <= RST_GH;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OCT: oct_r <= cfg_data[3:0];
        CFG_LAC: lac_r <= cfg_data[11:0];
        CFG_PER: per_r <= cfg_data;
        CFG_GW:  gw_r  <= cfg_data[8:0];
        CFG_GH:  gh_r  <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we) grid_mem[waddr] <= wdata;
    if (cmd.rd_en) rdata_r <= grid_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.q_init) begin
      px_r  <= in_pos_x;
      py_r  <= in_pos_y;
      o_r   <= o_init;
      i_r   <= '0;
      p_r   <= POW_INIT;
      amp_r <= AMP_INIT;
      tot_r <= '0;
      sum_r <= '0;
      res_r <= '0;
    end
    if (cmd.pow_step) begin
      p_r <= p_n;
      i_r <= i_r + 1'b1;
    end
    if (cmd.amp_step) begin
      amp_r <= amp_n;
      tot_r <= tot_r + TW'(amp_n);
    end
    if (cmd.div_cap) begin
      case (cmd.div_op)
        DOP_WMOD: begin
          rwx_r <= rx[GWW-1:0];
          rwy_r <= ry[GWW-1:0];
        end
        DOP_PMOD: begin
          rmx_r <= rx[GWW-1:0];
          rmy_r <= ry[GWW-1:0];
        end
        default: begin
          ax_r <= qx[14:0];
          ay_r <= qy[14:0];
          x0_r <= x0m[7:0];
          y0_r <= y0m[7:0];
        end
      endcase
    end
    if (cmd.crn) begin
      xa_r <= rmx_r;
      xb_r <= wrap_add(rmx_r, rwx_r, gw_c);
      ya_r <= rmy_r;
      yb_r <= wrap_add(rmy_r, rwy_r, gh_c);
    end
    if (cmd.cap_en) v_r[cmd.cap_sel] <= rdata_r;
    if (cmd.bl_en) begin
      case (cmd.bl_sel)
        BL_TOP:  top_r <= lerp(v_r[2], v_r[3], ax_r);
        BL_MID:  ov_r  <= lerp(bot_r, top_r, ay_r);
        default: bot_r <= lerp(v_r[0], v_r[1], ax_r);
      endcase
    end
    if (cmd.mul) prod_r <= PW'(ov_r) * PW'(amp_r);
    if (cmd.acc) begin
      sum_r <= sum_r + SW'(prod_r);
      if (o_r != '0) begin
        o_r <= o_r - 1'b1;
        i_r <= '0;
        p_r <= POW_INIT;
      end
    end
    if (cmd.fd_cap) res_r <= fq[15:0];
    if (cmd.out_fire) begin
      out_x_r <= px_r;
      out_y_r <= py_r;
      out_n_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= cmd.out_fire;
  end

  assign out_valid       = out_valid_r;
  assign out_x           = out_x_r;
  assign out_y           = out_y_r;
  assign out_noise_value = out_n_r;
endmodule

### sv/fractal_value_noise_pixel.sv
`timescale 1ns / 1ps
// fractal value noise, one pixel per query item
// items enter on start while busy is low; in_action selects load or query
// a load writes one grid sample in the accepting cycle and gives no result
// a query gives one result: out_valid is high for one cycle with out_x,
// out_y and out_noise_value; the receiver cannot hold it off
// a query with zero octaves goes straight to the output state and gives zero
// otherwise octave o (min(octave_count, MAX_OCTAVES)-1 down to 0) runs
// o steps of the power multiplier, then three 25-step serial dividers run
// per axis in two lanes (blend, wavelength wrap, corner wrap), four reads
// of the single-port grid memory, three lerps and a multiply-accumulate
// the final normalising divide is serial, one bit per cycle, and takes
// SAMPLE_BITS + 40 steps at the default MAX_OCTAVES
// only one query is worked on at a time; busy stays high until it is done
// reset restores the configuration defaults and idles the controller
// grid contents are undefined after reset until loaded
// configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
module fractal_value_noise_pixel #(
  parameter int GRID_SIDE   = 256,
  parameter int MAX_OCTAVES = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [7:0]  in_pos_x,
  input  logic [7:0]  in_pos_y,
  input  logic [15:0] in_sample,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  output logic [7:0]  out_x,
  output logic [7:0]  out_y,
  output logic [15:0] out_noise_value
);
  import fvn_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  fvn_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_action(in_action),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  fvn_dpath #(
    .GRID_SIDE(GRID_SIDE), .MAX_OCTAVES(MAX_OCTAVES), .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dpath (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .in_sample(in_sample), .cmd(cmd), .sts(sts), .out_valid(out_valid),
    .out_x(out_x), .out_y(out_y), .out_noise_value(out_noise_value)
  );
endmodule

### tb/fvn_checker.sv
`timescale 1ns / 1ps
module fvn_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_action,
  input  logic [7:0]  in_pos_x,
  input  logic [7:0]  in_pos_y,
  input  logic [15:0] in_sample,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        out_valid,
  input  logic [7:0]  out_x,
  input  logic [7:0]  out_y,
  input  logic [15:0] out_noise_value,
  output int          fail_count,
  output int          pending_pixels
);
  import fvn_pkg::*;

  typedef struct packed {
    logic [7:0]  x;
    logic [7:0]  y;
    logic [15:0] noise;
  } pixel_t;

  logic [15:0] grid_mirror [0:65535];
  logic [3:0]  octaves;
  logic [11:0] lacunarity;
  logic [15:0] persistence;
  logic [8:0]  width_cfg;
  logic [8:0]  height_cfg;
  pixel_t      pixel_queue[$];

  function automatic longint unsigned lerp(longint unsigned v0, longint unsigned v1,
                                           longint unsigned a);
    return (v0 * (64'd32768 - a) + v1 * a) >> 15;
  endfunction

  function automatic logic [15:0] predict_noise(logic [7:0] px8, logic [7:0] py8);
    longint unsigned n, lac, per, gw, gh, amp, total, sum, p, w, px, py;
    longint unsigned x0, y0, ax, ay, xa, xb, ya, yb, bot, top_v;
    n = (octaves > 8) ? 8 : octaves;
    lac = (lacunarity < LAC_MIN) ? LAC_MIN : lacunarity;
    per = (persistence < PERS_MIN) ? PERS_MIN : persistence;
    gw = (width_cfg == 0) ? 1 : (width_cfg > 256) ? 256 : width_cfg;
    gh = (height_cfg == 0) ? 1 : (height_cfg > 256) ? 256 : height_cfg;
    px = px8;
    py = py8;
    amp = 16384;
    total = 0;
    sum = 0;
    if (n == 0) return 16'd0;
    for (int k = int'(n) - 1; k >= 0; k--) begin
      p = 256;
      for (int i = 0; i < k; i++) begin
        p = (p * lac) >> 8;
        if (p > 64'h1_0000_0000) p = 64'h1_0000_0000;
      end
      w = p >> 8;
      amp = (amp * per) >> 14;
      if (amp > 64'h8_0000_0000) amp = 64'h8_0000_0000;
      total += amp;
      x0 = px / w * w;
      y0 = py / w * w;
      ax = ((px - x0) << 15) / w;
      ay = ((py - y0) << 15) / w;
      xa = x0 % gw;
      xb = (x0 + w) % gw;
      ya = y0 % gh;
      yb = (y0 + w) % gh;
      bot = lerp(grid_mirror[ya * 256 + xa], grid_mirror[ya * 256 + xb], ax);
      top_v = lerp(grid_mirror[yb * 256 + xa], grid_mirror[yb * 256 + xb], ax);
      sum += lerp(bot, top_v, ay) * amp;
    end
    if (total == 0) return 16'd0;
    return 16'((sum / total) & 64'hFFFF);
  endfunction

  always @(posedge clk) begin
    pixel_t got, want;
    if (!rst_n) begin
      octaves     <= RST_OCT;
      lacunarity  <= RST_LAC;
      persistence <= RST_PER;
      width_cfg   <= RST_GW;
      height_cfg  <= RST_GH;
      pixel_queue.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_OCT: octaves     <= cfg_data[3:0];
          CFG_LAC: lacunarity  <= cfg_data[11:0];
          CFG_PER: persistence <= cfg_data;
          CFG_GW:  width_cfg   <= cfg_data[8:0];
          CFG_GH:  height_cfg  <= cfg_data[8:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (in_action == ACT_LOAD) begin
          grid_mirror[{in_pos_y, in_pos_x}] = in_sample;
        end else begin
          want.x = in_pos_x;
          want.y = in_pos_y;
          want.noise = predict_noise(in_pos_x, in_pos_y);
          pixel_queue.push_back(want);
        end
      end
      if (out_valid) begin
        got = '{x: out_x, y: out_y, noise: out_noise_value};
        if (pixel_queue.size() == 0) begin
          $error("pixel result with none pending: x=%0d y=%0d noise=%0d",
                 out_x, out_y, out_noise_value);
          fail_count++;
        end else begin
          want = pixel_queue.pop_front();
          if (got.x !== want.x) begin
            $error("out_x expected %0d actual %0d", want.x, got.x);
            fail_count++;
          end
          if (got.y !== want.y) begin
            $error("out_y expected %0d actual %0d", want.y, got.y);
            fail_count++;
          end
          if (got.noise !== want.noise) begin
            $error("noise_value expected %0d actual %0d", want.noise, got.noise);
            fail_count++;
          end
        end
      end
    end
    pending_pixels = pixel_queue.size();
  end

  initial begin
    fail_count = 0;
    pending_pixels = 0;
  end

endmodule

### tb/tb_fractal_value_noise_pixel.sv
`timescale 1ns / 1ps
module tb_fractal_value_noise_pixel;
  import fvn_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_action;
  logic [7:0]  in_pos_x;
  logic [7:0]  in_pos_y;
  logic [15:0] in_sample;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        out_valid;
  logic [7:0]  out_x;
  logic [7:0]  out_y;
  logic [15:0] out_noise_value;
  int          fail_count;
  int          pending_pixels;
  int          cycle_count;
  int          loads_sent;
  int          queries_sent;
  bit          gaps_on;

  localparam int CYCLE_LIMIT = 6000000;

  fractal_value_noise_pixel DUT (.*);

  fvn_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(logic act, logic [7:0] x, logic [7:0] y, logic [15:0] s);
    start     <= 1'b1;
    in_action <= act;
    in_pos_x  <= x;
    in_pos_y  <= y;
    in_sample <= s;
    forever begin
      @(posedge clk);
      if (!busy) break;
      @(negedge clk);
    end
    @(negedge clk);
    if (act == ACT_LOAD) loads_sent++;
    else queries_sent++;
  endtask

  task automatic maybe_gap();
    int n;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 11);
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    start <= 1'b0;
    while (pending_pixels != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(int oct, int lac, int per, int gw, int gh);
    write_reg(CFG_OCT, 16'(oct));
    write_reg(CFG_LAC, 16'(lac));
    write_reg(CFG_PER, 16'(per));
    write_reg(CFG_GW, 16'(gw));
    write_reg(CFG_GH, 16'(gh));
  endtask

  task automatic random_items(int count);
    for (int i = 0; i < count; i++) begin
      maybe_gap();
      if ($urandom_range(0, 9) < 6)
        send_item(ACT_QUERY, 8'($urandom), 8'($urandom), 16'($urandom));
      else
        send_item(ACT_LOAD, 8'($urandom), 8'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_action = ACT_LOAD;
    in_pos_x = '0;
    in_pos_y = '0;
    in_sample = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_OCT;
    cfg_data = '0;
    cycle_count = 0;
    loads_sent = 0;
    queries_sent = 0;
    gaps_on = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // fill the 32 x 32 corner of the grid
    for (int k = 0; k < 1024; k++) begin
      if (k % 64 == 0) maybe_gap();
      send_item(ACT_LOAD, 8'(k % 32), 8'(k / 32), 16'($urandom));
    end

    // directed: extreme samples and positions at reset settings, then extreme register settings
    send_item(ACT_LOAD, 8'd0, 8'd0, 16'hFFFF);
    send_item(ACT_LOAD, 8'd31, 8'd31, 16'h0000);
    send_item(ACT_LOAD, 8'd31, 8'd0, 16'h8000);
    send_item(ACT_LOAD, 8'd0, 8'd31, 16'h7FFF);
    send_item(ACT_QUERY, 8'd0, 8'd0, 16'h0000);
    send_item(ACT_QUERY, 8'd23, 8'd23, 16'hFFFF);
    send_item(ACT_QUERY, 8'd23, 8'd0, 16'h0000);
    send_item(ACT_QUERY, 8'd0, 8'd23, 16'h0000);
    send_item(ACT_QUERY, 8'd1, 8'd3, 16'h0000);
    set_config(0, 512, 8192, 256, 256);
    send_item(ACT_QUERY, 8'd77, 8'd200, 16'h0000);
    set_config(15, 0, 0, 0, 0);
    send_item(ACT_QUERY, 8'd255, 8'd128, 16'h0000);
    send_item(ACT_QUERY, 8'd5, 8'd9, 16'h0000);
    set_config(8, 100, 65535, 511, 300);
    send_item(ACT_QUERY, 8'd30, 8'd30, 16'h0000);
    send_item(ACT_QUERY, 8'd17, 8'd2, 16'h0000);
    set_config(8, 4095, 65535, 32, 20);
    send_item(ACT_QUERY, 8'd255, 8'd255, 16'h0000);
    send_item(ACT_QUERY, 8'd17, 8'd240, 16'h0000);
    set_config(8, 255, 163, 1, 256);
    send_item(ACT_QUERY, 8'd200, 8'd10, 16'h0000);
    set_config(3, 384, 164, 7, 13);
    send_item(ACT_QUERY, 8'd250, 8'd250, 16'h0000);
    send_item(ACT_QUERY, 8'd6, 8'd12, 16'h0000);

    // random phases with several register settings
    set_config(4, 512, 8192, 32, 32);
    random_items(70);
    set_config(8, 4095, 65535, 32, 1);
    random_items(70);
    set_config(1, 256, 16384, 17, 31);
    random_items(70);
    set_config(15, 1000, 40000, 5, 0);
    random_items(70);
    for (int ph = 0; ph < 4; ph++) begin
      set_config($urandom_range(0, 15), $urandom_range(0, 4095), $urandom_range(0, 65535),
                 $urandom_range(0, 32), $urandom_range(0, 32));
      random_items(40);
    end
    gaps_on = 1'b0;
    set_config(6, 640, 12000, 24, 30);
    random_items(60);

    start <= 1'b0;
    while (pending_pixels != 0 || busy) @(negedge clk);
    repeat (1000) @(negedge clk);

    $display("run covered %0d grid loads and %0d pixel queries", loads_sent, queries_sent);
    $display("register extremes, out-of-range grid sizes and octave counts included");
    if (fail_count == 0 && pending_pixels == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
sv/fvn_pkg.sv
sv/fvn_div.sv
sv/fvn_ctrl.sv
sv/fvn_dpath.sv
sv/fractal_value_noise_pixel.sv
tb/fvn_checker.sv
tb/tb_fractal_value_noise_pixel.sv
